[rtl/core/srti_pkg.sv]
// Shared constants and types for the sorted region table block.
package srti_pkg;

    // Default number of entries in each table's region memory.
    localparam int unsigned RegionsDefault = 128;

    // Item action codes.
    localparam logic ActAdd   = 1'b0;
    localparam logic ActQuery = 1'b1;

    // Result status codes.
    localparam logic StsOk     = 1'b0;
    localparam logic StsNoRoom = 1'b1;

    // A base and size pair as stored in a table.
    typedef struct packed {
        logic [63:0] base;
        logic [63:0] size;
    } t_region;

endpackage

[rtl/core/sorted_region_table_insert_merge.sv]
// Top level: two sorted region tables with insert, merge and overlap query.
//
// The block keeps a memory table and a reserved table of sorted, non-touching
// address regions, each held in its own single-port synchronous memory of
// REGIONS entries. An add item caps the size so the end does not wrap, then
// inserts the range and merges every region it touches, adding the newly
// covered bytes to the table's total. A query item reports whether any region
// overlaps the range. Items are handled one at a time. Memory reads are
// registered, so the cost is set by the memory port: a query reads the
// regions in turn until one overlaps, and an add scans the regions, then
// shifts or compacts the entries from the first region past the range
// onward before it writes the merged region. A result stays in an output
// register until taken. The memories need no clearing: only entries below the
// region count are read.
module sorted_region_table_insert_merge
    import srti_pkg::*;
#(
    parameter int unsigned REGIONS = RegionsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic        i_table_sel,
    input  logic [63:0] i_range_base,
    input  logic [63:0] i_range_size,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_status,
    output logic        o_overlaps,
    output logic [7:0]  o_region_count,
    output logic [63:0] o_total_bytes
);

    localparam int unsigned AW = $clog2(REGIONS);
    localparam int unsigned CW = $clog2(REGIONS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_PLAN,
        S_INS_RD,
        S_INS_WR,
        S_CMP_RD,
        S_CMP_WR,
        S_FINAL,
        S_DONE
    } t_state;

    // Region memories, one per table.
    t_region mem_m [REGIONS];
    t_region mem_r [REGIONS];

    t_state      r_state;
    logic        r_action;
    logic        r_sel;
    logic [63:0] r_b;
    logic [63:0] r_s;
    logic [63:0] r_e;
    logic [CW-1:0] r_cnt_m, r_cnt_r;
    logic [63:0] r_tot_m, r_tot_r;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_n;
    logic        r_found_i;
    logic [63:0] r_cov;
    logic [63:0] r_nb, r_ne;
    logic        r_ovl;
    logic        r_valid;
    logic        r_status;
    logic [7:0]  r_count_o;
    logic [63:0] r_total_o;

    // Memory port of the selected table.
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    t_region       mem_wdata;
    t_region       rd_m, rd_r, rd;

    always_ff @(posedge i_clk) begin
        if (mem_we && !r_sel) begin
            mem_m[mem_addr] <= mem_wdata;
        end
        rd_m <= mem_m[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we && r_sel) begin
            mem_r[mem_addr] <= mem_wdata;
        end
        rd_r <= mem_r[mem_addr];
    end

    assign rd = r_sel ? rd_r : rd_m;

    logic [CW-1:0] cnt;
    assign cnt = r_sel ? r_cnt_r : r_cnt_m;

    // Capping of the incoming size.
    logic [63:0] room, capped;
    assign room   = 64'hFFFF_FFFF_FFFF_FFFF - i_range_base;
    assign capped = (i_range_size < room) ? i_range_size : room;

    // Per-entry compare logic on the read data.
    logic [63:0] re, lo, hi;
    assign re = rd.base + rd.size;
    assign lo = (rd.base > r_b) ? rd.base : r_b;
    assign hi = (re < r_e) ? re : r_e;

    // The number of absorbed regions, valid while r_k marks the end of the scan.
    logic [CW-1:0] n_abs;
    assign n_abs = r_k - r_i;

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_k[AW-1:0];
        mem_wdata = '0;
        unique case (r_state)
            S_INS_RD: mem_addr = AW'(r_k - CW'(1));
            S_INS_WR: begin
                mem_we    = 1'b1;
                mem_addr  = r_k[AW-1:0];
                mem_wdata = rd;
            end
            S_CMP_WR: begin
                mem_we    = 1'b1;
                mem_addr  = AW'(r_k - r_n + CW'(1));
                mem_wdata = rd;
            end
            S_FINAL: begin
                mem_we         = 1'b1;
                mem_addr       = r_i[AW-1:0];
                mem_wdata.base = r_nb;
                mem_wdata.size = r_ne - r_nb;
            end
            default: mem_addr = r_k[AW-1:0];
        endcase
    end

    assign o_ready        = (r_state == S_IDLE) && !r_valid;
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_overlaps     = r_ovl;
    assign o_region_count = r_count_o;
    assign o_total_bytes  = r_total_o;

    // Sequencer for scan, shift, compaction and write of the merged region.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt_m <= '0;
            r_cnt_r <= '0;
            r_tot_m <= '0;
            r_tot_r <= '0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_action  <= i_action;
                        r_sel     <= i_table_sel;
                        r_b       <= i_range_base;
                        r_s       <= capped;
                        r_e       <= i_range_base + capped;
                        r_k       <= '0;
                        r_i       <= '0;
                        r_found_i <= 1'b0;
                        r_cov     <= '0;
                        r_ovl     <= 1'b0;
                        r_state   <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    if (r_action == ActAdd) begin
                        if (r_s == 64'd0) begin
                            r_status <= StsOk;
                            r_state  <= S_DONE;
                        end else if ({1'b0, cnt} + (CW + 1)'(2) > (CW + 1)'(REGIONS)) begin
                            r_status <= StsNoRoom;
                            r_state  <= S_DONE;
                        end else if (r_k == cnt) begin
                            r_state <= S_PLAN;
                        end else begin
                            r_state <= S_SCAN_CHK;
                        end
                    end else if (r_k == cnt || r_ovl) begin
                        r_status <= StsOk;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK: begin
                    r_state <= S_SCAN_RD;
                    r_k     <= r_k + CW'(1);
                    if (r_action == ActQuery) begin
                        if (r_b < re && rd.base < r_e) begin
                            r_ovl <= 1'b1;
                        end
                    end else if (!r_found_i) begin
                        if (re < r_b) begin
                            r_i <= r_k + CW'(1);
                        end else if (rd.base <= r_e) begin
                            r_found_i <= 1'b1;
                            r_nb      <= (rd.base < r_b) ? rd.base : r_b;
                            r_ne      <= (re > r_e) ? re : r_e;
                            if (hi > lo) r_cov <= hi - lo;
                        end else begin
                            r_state <= S_PLAN;
                            r_k     <= r_k;
                        end
                    end else if (rd.base <= r_e) begin
                        r_ne <= (re > r_e) ? re : r_e;
                        if (hi > lo) r_cov <= r_cov + (hi - lo);
                    end else begin
                        r_state <= S_PLAN;
                        r_k     <= r_k;
                    end
                end
                S_PLAN: begin
                    // r_k now marks the first region beyond the range.
                    if (!r_found_i) begin
                        r_nb <= r_b;
                        r_ne <= r_e;
                        r_k  <= cnt;
                        r_state <= (cnt > r_i) ? S_INS_RD : S_FINAL;
                        if (r_sel) r_cnt_r <= r_cnt_r + CW'(1);
                        else       r_cnt_m <= r_cnt_m + CW'(1);
                    end else begin
                        r_n     <= n_abs;
                        r_state <= (r_k < cnt && n_abs > CW'(1)) ? S_CMP_RD : S_FINAL;
                        if (r_sel) r_cnt_r <= r_cnt_r - n_abs + CW'(1);
                        else       r_cnt_m <= r_cnt_m - n_abs + CW'(1);
                    end
                end
                S_INS_RD: r_state <= S_INS_WR;
                S_INS_WR: begin
                    r_k     <= r_k - CW'(1);
                    r_state <= (r_k - CW'(1) > r_i) ? S_INS_RD : S_FINAL;
                end
                S_CMP_RD: r_state <= S_CMP_WR;
                S_CMP_WR: begin
                    // Compaction bound is the count before the merge.
                    r_k     <= r_k + CW'(1);
                    r_state <= (r_k + CW'(1) < cnt + r_n - CW'(1)) ? S_CMP_RD : S_FINAL;
                end
                S_FINAL: begin
                    if (r_sel) r_tot_r <= r_tot_r + (r_s - r_cov);
                    else       r_tot_m <= r_tot_m + (r_s - r_cov);
                    r_status <= StsOk;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_valid) begin
                        r_valid   <= 1'b1;
                        r_count_o <= 8'(cnt);
                        r_total_o <= r_sel ? r_tot_r : r_tot_m;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[verif/tb_sorted_region_table_insert_merge.sv]
// Testbench for the sorted region table block: random and directed adds and queries checked against a predictor.
module tb_sorted_region_table_insert_merge;
    import srti_pkg::*;

    localparam int unsigned NREG = RegionsDefault;
    localparam int unsigned NUM_RANDOM = 1150;

    typedef struct {
        logic        action;
        logic        table_sel;
        logic [63:0] base;
        logic [63:0] size;
    } t_item;

    typedef struct {
        logic        status;
        logic        overlaps;
        logic [7:0]  count;
        logic [63:0] total;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_action;
    logic        i_table_sel;
    logic [63:0] i_range_base;
    logic [63:0] i_range_size;
    logic        o_valid;
    logic        i_ready;
    logic        o_status;
    logic        o_overlaps;
    logic [7:0]  o_region_count;
    logic [63:0] o_total_bytes;

    sorted_region_table_insert_merge i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_table_sel    (i_table_sel),
        .i_range_base   (i_range_base),
        .i_range_size   (i_range_size),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_overlaps     (o_overlaps),
        .o_region_count (o_region_count),
        .o_total_bytes  (o_total_bytes)
    );

    // Predictor state: one table per selector.
    logic [63:0] tbl_base [2][NREG];
    logic [63:0] tbl_size [2][NREG];
    int unsigned tbl_count [2];
    logic [63:0] tbl_total [2];

    t_item   pending_items[$];
    t_result expected_results[$];
    int      mismatches;
    bit      stim_done;
    bit      hold_sender;
    int      hold_receiver;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] capped_size(logic [63:0] b, logic [63:0] s);
        logic [63:0] room;
        room = 64'hFFFF_FFFF_FFFF_FFFF - b;
        return (s < room) ? s : room;
    endfunction

    // Compute the result of one item and update the predicted tables.
    function automatic t_result predict_region_step(t_item it);
        t_result     r;
        int          t;
        int unsigned cnt, i, j, n, k;
        logic [63:0] s, e, covered, nb, ne, lo, re, hi, le;
        t = it.table_sel;
        cnt = tbl_count[t];
        r.status = StsOk;
        r.overlaps = 1'b0;
        s = capped_size(it.base, it.size);
        if (it.action == ActQuery) begin
            for (k = 0; k < cnt; k++)
                if (it.base < tbl_base[t][k] + tbl_size[t][k] && tbl_base[t][k] < it.base + s)
                    r.overlaps = 1'b1;
        end else if (s != 0) begin
            if (cnt + 2 > NREG) begin
                r.status = StsNoRoom;
            end else begin
                e = it.base + s;
                i = 0;
                while (i < cnt && tbl_base[t][i] + tbl_size[t][i] < it.base) i++;
                j = i;
                covered = 0;
                while (j < cnt && tbl_base[t][j] <= e) begin
                    lo = (tbl_base[t][j] > it.base) ? tbl_base[t][j] : it.base;
                    re = tbl_base[t][j] + tbl_size[t][j];
                    hi = (re < e) ? re : e;
                    if (hi > lo) covered += hi - lo;
                    j++;
                end
                n = j - i;
                nb = it.base;
                ne = e;
                if (n > 0) begin
                    le = tbl_base[t][j-1] + tbl_size[t][j-1];
                    if (tbl_base[t][i] < nb) nb = tbl_base[t][i];
                    if (le > ne) ne = le;
                end
                if (n == 0) begin
                    for (k = cnt; k > i; k--) begin
                        tbl_base[t][k] = tbl_base[t][k-1];
                        tbl_size[t][k] = tbl_size[t][k-1];
                    end
                    cnt++;
                end else if (n > 1) begin
                    for (k = j; k < cnt; k++) begin
                        tbl_base[t][k-n+1] = tbl_base[t][k];
                        tbl_size[t][k-n+1] = tbl_size[t][k];
                    end
                    cnt -= n - 1;
                end
                tbl_base[t][i] = nb;
                tbl_size[t][i] = ne - nb;
                tbl_count[t] = cnt;
                tbl_total[t] += s - covered;
            end
        end
        r.count = tbl_count[t][7:0];
        r.total = tbl_total[t];
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_item mk(logic a, logic t, logic [63:0] b, logic [63:0] s);
        t_item it;
        it.action = a;
        it.table_sel = t;
        it.base = b;
        it.size = s;
        return it;
    endfunction

    // Random item; most use a small address window so regions touch and merge.
    function automatic t_item random_item(int mode);
        t_item it;
        int    r;
        it.action = ($urandom_range(0, 2) == 0) ? ActQuery : ActAdd;
        it.table_sel = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 19);
        if (mode == 1) begin
            // Spread-out small ranges fill the memory table quickly.
            it.action = ActAdd;
            it.table_sel = 1'b0;
            it.base = 64'($urandom_range(0, 32'hFFFF)) * 64'd64;
            it.size = 64'($urandom_range(1, 20));
        end else if (r < 14) begin
            it.base = 64'($urandom_range(0, 4000));
            it.size = 64'($urandom_range(0, 60));
        end else if (r < 17) begin
            it.base = rand64();
            it.size = rand64() >> $urandom_range(0, 63);
        end else if (r < 19) begin
            it.base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 100));
            it.size = rand64();
        end else begin
            it.base = 64'($urandom_range(0, 4000));
            it.size = rand64();
        end
        return it;
    endfunction

    // Stimulus: directed part, then random phases.
    initial begin
        for (int t = 0; t < 2; t++) begin
            tbl_count[t] = 0;
            tbl_total[t] = 0;
        end
        stim_done = 1'b0;
        hold_sender = 1'b0;
        // Extremes, zero sizes, touching and covering adds, queries of zero size.
        pending_items.push_back(mk(ActQuery, 0, 0, 0));
        pending_items.push_back(mk(ActAdd, 0, 100, 0));
        pending_items.push_back(mk(ActAdd, 0, 100, 50));
        pending_items.push_back(mk(ActAdd, 0, 150, 10));
        pending_items.push_back(mk(ActAdd, 0, 90, 10));
        pending_items.push_back(mk(ActAdd, 0, 300, 20));
        pending_items.push_back(mk(ActAdd, 0, 120, 10));
        pending_items.push_back(mk(ActAdd, 0, 80, 400));
        pending_items.push_back(mk(ActQuery, 0, 100, 0));
        pending_items.push_back(mk(ActQuery, 0, 479, 1));
        pending_items.push_back(mk(ActQuery, 0, 480, 5));
        pending_items.push_back(mk(ActAdd, 1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_items.push_back(mk(ActAdd, 1, 64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_items.push_back(mk(ActQuery, 1, 64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_items.push_back(mk(ActAdd, 1, 0, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_items.push_back(mk(ActQuery, 1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
        pending_items.push_back(mk(ActAdd, 1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
        pending_items.push_back(mk(ActQuery, 1, 0, 1));
        pending_items.push_back(mk(ActQuery, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        @(posedge i_rst_n);
        // Random phase with many short items.
        for (int n = 0; n < NUM_RANDOM / 2; n++) pending_items.push_back(random_item(0));
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        // Sender pause once every result is back.
        hold_sender = 1'b1;
        repeat (20) @(posedge i_clk);
        hold_sender = 1'b0;
        // Fill the memory table to full, then hit the refusal with more adds.
        for (int n = 0; n < 180; n++) pending_items.push_back(random_item(1));
        pending_items.push_back(mk(ActAdd, 0, 5, 0));
        pending_items.push_back(mk(ActAdd, 0, 200, 5));
        for (int n = 0; n < NUM_RANDOM / 2 - 180; n++) pending_items.push_back(random_item(0));
        wait (pending_items.size() == 0);
        stim_done = 1'b1;
    end

    // Reset and fixed end-of-run watchdog.
    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #(64'd12 * 64'd4000000);
        $display("simulation failed");
        $finish;
    end

    // Driver: offers items from the pending queue with random gaps.
    int drv_gap;
    initial begin
        i_valid = 1'b0;
        i_action = 1'b0;
        i_table_sel = 1'b0;
        i_range_base = '0;
        i_range_size = '0;
        drv_gap = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_results.push_back(predict_region_step(pending_items.pop_front()));
                drv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            end
            if ((!i_valid || o_ready) && drv_gap > 0) begin
                drv_gap--;
                i_valid <= 1'b0;
            end else if ((!i_valid || o_ready) ) begin
                if (pending_items.size() > (i_valid && o_ready ? 0 : 0) && !hold_sender &&
                    pending_items.size() != 0) begin
                    i_valid <= 1'b1;
                    i_action <= pending_items[0].action;
                    i_table_sel <= pending_items[0].table_sel;
                    i_range_base <= pending_items[0].base;
                    i_range_size <= pending_items[0].size;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stalls, one long hold-off, and the field checks.
    int rcv_gap;
    int accepted_results;
    initial begin
        i_ready = 1'b0;
        rcv_gap = 0;
        accepted_results = 0;
        mismatches = 0;
        hold_receiver = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                accepted_results++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result item");
                end else begin
                    t_result x;
                    x = expected_results.pop_front();
                    if (o_status !== x.status || o_overlaps !== x.overlaps ||
                        o_region_count !== x.count || o_total_bytes !== x.total) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp st=%0b ov=%0b cnt=%0d tot=%h got st=%0b ov=%0b cnt=%0d tot=%h",
                                     x.status, x.overlaps, x.count, x.total,
                                     o_status, o_overlaps, o_region_count, o_total_bytes);
                    end
                end
                rcv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                if (accepted_results == 40) hold_receiver = 6000;
            end
            if (hold_receiver > 0) begin
                hold_receiver--;
                i_ready <= 1'b0;
            end else if (rcv_gap > 0) begin
                rcv_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // End of run.
    initial begin
        @(posedge i_rst_n);
        wait (stim_done && !i_valid && expected_results.size() == 0);
        repeat (600) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
